### hw/rtl/bumw_pkg.sv
// ----------------------------------------------------------------------------
// bumw_pkg
// Shared types and constants of the banked unaligned word memory: request and
// response payloads, controller/datapath command and status, register codes.
// ----------------------------------------------------------------------------
package bumw_pkg;

    localparam int ADDR_W       = 16;
    localparam int WORD_W       = 32;
    localparam int WORD_BYTES   = 4;
    localparam int SIZE_W       = 15;
    localparam int COUNT_W      = 3;
    localparam int CFG_IDX_W    = 1;
    localparam int DIV_CNT_W    = $clog2(ADDR_W);
    localparam int BYTE_CNT_W   = $clog2(WORD_BYTES);

    // Default geometry, handed to the top-level parameters.
    localparam int DEF_MAX_CHIPS      = 4;
    localparam int DEF_MAX_CHIP_BYTES = 16384;

    // Register reset values.
    localparam logic [SIZE_W-1:0]  RST_CHIP_BYTES = SIZE_W'(16384);
    localparam logic [COUNT_W-1:0] RST_CHIP_COUNT = COUNT_W'(4);
    localparam int                 MIN_CHIP_BYTES = WORD_BYTES;

    // Register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_CHIP_BYTES = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_CHIP_COUNT = 1'b1;

    // Operation codes.
    localparam logic OP_READ  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    // Status codes.
    localparam logic [1:0] STATUS_DONE      = 2'd0;
    localparam logic [1:0] STATUS_BAD_CHIP  = 2'd1;
    localparam logic [1:0] STATUS_SPILL_OUT = 2'd2;

    typedef struct packed {
        logic              operation;
        logic [ADDR_W-1:0] address;
        logic [WORD_W-1:0] write_data;
    } t_in_req;

    typedef struct packed {
        logic [WORD_W-1:0] read_data;
        logic [1:0]        status;
    } t_out_rsp;

    typedef struct packed {
        logic load;      // capture request, seed divider
        logic div_step;  // one restoring divide step
        logic check;     // classify request, set byte pointer
        logic access;    // one byte of memory traffic
        logic publish;   // load response register
    } t_dp_cmd;

    typedef struct packed {
        logic fault;     // request ends without memory traffic
    } t_dp_sts;

endpackage

### hw/rtl/bumw_ctrl.sv
// ----------------------------------------------------------------------------
// bumw_ctrl
// Sequencer of the banked memory: divide, classify, byte accesses, response.
// ----------------------------------------------------------------------------
module bumw_ctrl
    import bumw_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_CHECK,
        S_ACCESS,
        S_TAIL,
        S_FINISH
    } t_state;

    t_state                r_state, n_state;
    logic [DIV_CNT_W-1:0]  r_div_cnt, n_div_cnt;
    logic [BYTE_CNT_W-1:0] r_byte_cnt, n_byte_cnt;
    logic                  r_out_valid, n_out_valid;
    logic                  out_free;

    assign out_free    = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state     = r_state;
        n_div_cnt   = r_div_cnt;
        n_byte_cnt  = r_byte_cnt;
        n_out_valid = r_out_valid;
        o_cmd       = '0;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_div_cnt  = '0;
                    n_state    = S_DIV;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_div_cnt      = r_div_cnt + 1'b1;
                if (r_div_cnt == DIV_CNT_W'(ADDR_W - 1)) begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                o_cmd.check = 1'b1;
                n_byte_cnt  = '0;
                n_state     = i_sts.fault ? S_FINISH : S_ACCESS;
            end
            S_ACCESS: begin
                o_cmd.access = 1'b1;
                n_byte_cnt   = r_byte_cnt + 1'b1;
                if (r_byte_cnt == BYTE_CNT_W'(WORD_BYTES - 1)) begin
                    n_state = S_TAIL;
                end
            end
            S_TAIL: begin
                n_state = S_FINISH;
            end
            S_FINISH: begin
                if (out_free) begin
                    o_cmd.publish = 1'b1;
                    n_out_valid   = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_div_cnt   <= '0;
            r_byte_cnt  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_div_cnt   <= n_div_cnt;
            r_byte_cnt  <= n_byte_cnt;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

### hw/rtl/bumw_dp.sv
// ----------------------------------------------------------------------------
// bumw_dp
// Datapath: restoring divider, request classifier, byte pointer, byte-wide
// storage array and response register.
// ----------------------------------------------------------------------------
module bumw_dp
    import bumw_pkg::*;
#(
    parameter int MAX_CHIPS      = DEF_MAX_CHIPS,
    parameter int MAX_CHIP_BYTES = DEF_MAX_CHIP_BYTES,
    parameter int CNT_W          = $clog2(MAX_CHIPS + 1)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_dp_cmd           i_cmd,
    output t_dp_sts           o_sts,
    input  t_in_req           i_in,
    input  logic [SIZE_W-1:0] i_size,
    input  logic [CNT_W-1:0]  i_count,
    output t_out_rsp          o_out
);

    localparam int DEPTH  = MAX_CHIPS * MAX_CHIP_BYTES;
    localparam int AW     = $clog2(DEPTH);
    localparam int CHIP_W = (MAX_CHIPS > 1) ? $clog2(MAX_CHIPS) : 1;

    logic [7:0]        mem [DEPTH];

    logic              r_op;
    logic [WORD_W-1:0] r_wdata;
    logic [ADDR_W-1:0] r_quo;
    logic [SIZE_W-1:0] r_rem;
    logic [1:0]        r_status;
    logic [CHIP_W-1:0] r_chip;
    logic [SIZE_W-1:0] r_off;
    logic [WORD_W-1:0] r_word;
    logic [7:0]        r_rd_byte;
    logic              r_rd_pend;
    t_out_rsp          r_out;

    logic [SIZE_W:0]   trial;
    logic              trial_ge;
    logic [1:0]        chk_status;
    logic [SIZE_W:0]   off_inc;
    logic [AW-1:0]     slot;

    // Restoring divide step: remainder stays below the chip size.
    assign trial    = {r_rem, r_quo[ADDR_W-1]};
    assign trial_ge = (trial >= {1'b0, i_size});

    // Classify from quotient (chip) and remainder (offset).
    always_comb begin
        chk_status = STATUS_DONE;
        if (r_quo >= ADDR_W'(i_count)) begin
            chk_status = STATUS_BAD_CHIP;
        end else if ((17'(r_rem) + 17'(WORD_BYTES) > 17'(i_size)) &&
                     (17'(r_quo) + 17'd1 >= 17'(i_count))) begin
            chk_status = STATUS_SPILL_OUT;
        end
    end

    assign o_sts.fault = (chk_status != STATUS_DONE);

    assign off_inc = {1'b0, r_off} + 1'b1;
    assign slot    = AW'(r_chip) * AW'(MAX_CHIP_BYTES) + AW'(r_off);

    always_ff @(posedge i_clk) begin
        if (i_cmd.access) begin
            if (r_op == OP_WRITE) begin
                mem[slot] <= r_wdata[7:0];
            end
            r_rd_byte <= mem[slot];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_pend <= 1'b0;
        end else begin
            r_rd_pend <= i_cmd.access;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op    <= i_in.operation;
            r_wdata <= i_in.write_data;
            r_quo   <= i_in.address;
            r_rem   <= '0;
        end
        if (i_cmd.div_step) begin
            r_rem <= trial_ge ? SIZE_W'(trial - {1'b0, i_size}) : trial[SIZE_W-1:0];
            r_quo <= {r_quo[ADDR_W-2:0], trial_ge};
        end
        if (i_cmd.check) begin
            r_status <= chk_status;
            r_chip   <= CHIP_W'(r_quo);
            r_off    <= r_rem;
        end
        if (i_cmd.access) begin
            r_wdata <= r_wdata >> 8;
            // Advance; wrap into the next chip at the chip end.
            if (off_inc == {1'b0, i_size}) begin
                r_off  <= '0;
                r_chip <= r_chip + 1'b1;
            end else begin
                r_off <= off_inc[SIZE_W-1:0];
            end
        end
        if (i_cmd.check) begin
            r_word <= '0;
        end else if (r_rd_pend) begin
            r_word <= {r_rd_byte, r_word[WORD_W-1:8]};
        end
        if (i_cmd.publish) begin
            r_out.read_data <= (r_op == OP_READ && r_status == STATUS_DONE) ? r_word : '0;
            r_out.status    <= r_status;
        end
    end

    assign o_out = r_out;

endmodule

### hw/rtl/banked_unaligned_word_memory.sv
// ----------------------------------------------------------------------------
// banked_unaligned_word_memory
// Byte-addressed memory of equal chips with unaligned 32-bit word access.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on i_in / i_in_valid / o_in_ready: a read or write of one
//   little-endian word at any byte address. Each request yields exactly one
//   response on o_out / o_out_valid / i_out_ready with read data and status.
//   The address is split into chip and offset by a one-bit-per-cycle
//   restoring divider over the 16 address bits; that divider sets most of
//   the latency. Bytes then move one per cycle through the single port of
//   the storage array.
//   Sequence: a request that touches memory goes through the divide steps,
//   the classify step, the byte accesses, a read tail and the response
//   load; one rejected with a nonzero status skips the accesses and tail.
//   A new request is taken only once the block is back in idle.
//   A finished response waits in the output register; the next request is
//   accepted and processed meanwhile, and holds in its final step only if
//   the previous response has still not been taken.
//   Configuration: i_cfg_index 0 writes chip_bytes, 1 writes chip_count;
//   o_cfg_ready is always high. Write only while idle.
//   Reset: synchronous, active low; chip_bytes returns to 16384 and
//   chip_count to 4. Storage is not cleared: no clearing pass is run.
// ----------------------------------------------------------------------------
module banked_unaligned_word_memory
    import bumw_pkg::*;
#(
    parameter int MAX_CHIPS      = DEF_MAX_CHIPS,
    parameter int MAX_CHIP_BYTES = DEF_MAX_CHIP_BYTES
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  t_in_req              i_in,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output t_out_rsp             o_out,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [SIZE_W-1:0]    i_cfg_data
);

    localparam int CNT_W = $clog2(MAX_CHIPS + 1);

    logic [SIZE_W-1:0]  r_chip_bytes;
    logic [COUNT_W-1:0] r_chip_count;
    logic [SIZE_W-1:0]  eff_size;
    logic [CNT_W-1:0]   eff_count;
    t_dp_cmd            cmd;
    t_dp_sts            sts;

    assign o_cfg_ready = 1'b1;

    // Hold configuration; chip_count takes the low bits of the write data.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chip_bytes <= RST_CHIP_BYTES;
            r_chip_count <= RST_CHIP_COUNT;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_CHIP_BYTES: r_chip_bytes <= i_cfg_data;
                CFG_CHIP_COUNT: r_chip_count <= i_cfg_data[COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    // Clamp chip size into word size .. MAX_CHIP_BYTES, chip count to MAX_CHIPS.
    always_comb begin
        if (r_chip_bytes < SIZE_W'(MIN_CHIP_BYTES)) begin
            eff_size = SIZE_W'(MIN_CHIP_BYTES);
        end else if (32'(r_chip_bytes) > 32'(MAX_CHIP_BYTES)) begin
            eff_size = SIZE_W'(MAX_CHIP_BYTES);
        end else begin
            eff_size = r_chip_bytes;
        end
        if (32'(r_chip_count) > 32'(MAX_CHIPS)) begin
            eff_count = CNT_W'(MAX_CHIPS);
        end else begin
            eff_count = CNT_W'(r_chip_count);
        end
    end

    bumw_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    bumw_dp #(
        .MAX_CHIPS      (MAX_CHIPS),
        .MAX_CHIP_BYTES (MAX_CHIP_BYTES),
        .CNT_W          (CNT_W)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .o_sts   (sts),
        .i_in    (i_in),
        .i_size  (eff_size),
        .i_count (eff_count),
        .o_out   (o_out)
    );

    // A rejected request never returns data.
    a_fault_no_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out.status != STATUS_DONE) |-> (o_out.read_data == '0))
        else $error("nonzero status with read data");

    // Only defined status codes leave the block.
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out.status == STATUS_DONE ||
                         o_out.status == STATUS_BAD_CHIP ||
                         o_out.status == STATUS_SPILL_OUT))
        else $error("undefined status code");

    // A response is loaded only from the final step, never while idle.
    a_rsp_from_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(!o_in_ready))
        else $error("response appeared while idle");

    // Accepting a request makes the block busy.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("still ready after accepting a request");

endmodule
